>>> rtl/core/assert_macros.svh
// Assertion helper macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/gld_pkg.sv
// ------------------------------------------------------------------------
// GIF LZW decoder package
// Shared types and constants of the decoder.
// ------------------------------------------------------------------------
`default_nettype none
package gld_pkg;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLACED = 3'd4;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [2:0] ST_PIXEL = 3'd0;
    localparam logic [2:0] ST_NONE = 3'd1;
    localparam logic [2:0] ST_NEED_DATA = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  pixel_index;
        logic [15:0] pixel_row;
        logic [15:0] pixel_column;
        logic [31:0] pixel_address;
    } t_out_item;
endpackage
`default_nettype wire

>>> rtl/core/gld_stream_if.sv
// ------------------------------------------------------------------------
// GIF LZW decoder stream interface
// Valid/ready channel carrying one payload item.
// ------------------------------------------------------------------------
`default_nettype none
interface gld_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/core/gld_ram.sv
// ------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ------------------------------------------------------------------------
`default_nettype none
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/gld_front.sv
// ------------------------------------------------------------------------
// GIF LZW decoder front end
// Accepts items and holds them in a two-entry queue for the back end.
// ------------------------------------------------------------------------
`default_nettype none
module gld_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_flush,
    gld_stream_if.sink          in_if,
    output gld_pkg::t_in_item   o_item,
    output logic                o_item_valid,
    input  wire logic           i_item_take
);
    import gld_pkg::*;
    t_in_item r_q [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic     push, pop;

    assign in_if.ready  = (r_cnt != 2'd2) && !i_flush;
    assign push         = in_if.valid && in_if.ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_item_take && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_if.payload;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/gld_back.sv
// ------------------------------------------------------------------------
// GIF LZW decoder back end
// Unpacks codes, walks the dictionary and emits pixels with coordinates.
// ------------------------------------------------------------------------
`default_nettype none
module gld_back #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [gld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire gld_pkg::t_in_item         i_item,
    input  wire logic                      i_item_valid,
    output logic                           o_item_take,
    gld_stream_if.source                   out_if
);
    import gld_pkg::*;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_ROW  = 3'd5;
    localparam logic [2:0] S_ADDR = 3'd6;

    logic [3:0]  r_init_size;
    logic [15:0] r_width, r_height;
    logic [17:0] r_pitch;
    logic        r_interlaced;

    logic [2:0]  r_state;
    logic [CW-1:0] r_sp;
    logic [31:0] r_acc;
    logic [5:0]  r_bits;
    logic [3:0]  r_csize;
    logic [CW-1:0] r_free;
    logic [11:0] r_prev;
    logic        r_prev_clr;
    logic [7:0]  r_first;
    logic [15:0] r_row, r_col;
    logic [31:0] r_emitted;
    logic        r_fin;
    logic [11:0] r_cur, r_code;
    logic [31:0] r_limit, r_addr;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [3:0]  eff;
    logic [12:0] clear_code;
    logic [11:0] prefix_rd;
    logic [7:0]  suffix_rd, stack_rd;
    logic        dict_we, stack_we;
    logic [AW-1:0] dict_waddr, stack_waddr, dict_raddr, stack_raddr;
    logic [7:0]  stack_wdata;
    logic [11:0] dict_wprefix;
    logic [7:0]  dict_wsuffix;
    logic        take;
    logic [11:0] code_now;
    logic [15:0] nrow;
    logic        link_in;

    function automatic logic [3:0] eff_of(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
        logic [3:0] s;
        s = (idx == REG_CODE_SIZE) ? d[3:0] : r_init_size;
        if (s < 4'd2) s = 4'd2;
        if (s > 4'd8) s = 4'd8;
        return s;
    endfunction

    // Result item that carries only a status; every other field is zero.
    function automatic t_out_item status_only(input logic [2:0] st);
        t_out_item it;
        it = '0;
        it.status = st;
        return it;
    endfunction

    always_comb begin
        eff = r_init_size;
        if (eff < 4'd2) eff = 4'd2;
        if (eff > 4'd8) eff = 4'd8;
    end
    assign clear_code = 13'd1 << eff;
    assign code_now = 12'(r_acc & ((32'd1 << r_csize) - 32'd1));

    gld_ram #(.WIDTH(12), .DEPTH(TABLE_ENTRIES)) u_prefix (
        .i_clk(i_clk), .i_we(dict_we), .i_waddr(dict_waddr), .i_wdata(dict_wprefix),
        .i_raddr(dict_raddr), .o_rdata(prefix_rd));
    gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
        .i_clk(i_clk), .i_we(dict_we), .i_waddr(dict_waddr), .i_wdata(dict_wsuffix),
        .i_raddr(dict_raddr), .o_rdata(suffix_rd));
    gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(stack_waddr), .i_wdata(stack_wdata),
        .i_raddr(stack_raddr), .o_rdata(stack_rd));

    assign link_in = ({1'b0, r_cur} >= clear_code + 13'd2)
                   && ({1'b0, r_cur} < 13'(TABLE_ENTRIES));
    assign dict_raddr = AW'(r_cur);
    assign stack_raddr = AW'(r_sp - CW'(1));
    assign dict_waddr = AW'(r_free);
    assign dict_wprefix = r_prev;
    assign dict_wsuffix = r_cur[7:0];

    // Next interlaced or linear row after r_row.
    always_comb begin
        logic [16:0] r8, r4, r2;
        r8 = {1'b0, r_row} + 17'd8;
        r4 = {1'b0, r_row} + 17'd4;
        r2 = {1'b0, r_row} + 17'd2;
        if (!r_interlaced) nrow = r_row + 16'd1;
        else if (r_row[2:0] == 3'd0) begin
            if (r8 < {1'b0, r_height}) nrow = r8[15:0];
            else if (r_height > 16'd4) nrow = 16'd4;
            else if (r_height > 16'd2) nrow = 16'd2;
            else nrow = 16'd1;
        end else if (r_row[1:0] == 2'd0) begin
            if (r8 < {1'b0, r_height}) nrow = r8[15:0];
            else if (r_height > 16'd2) nrow = 16'd2;
            else nrow = 16'd1;
        end else if (r_row[0] == 1'b0) begin
            if (r4 < {1'b0, r_height}) nrow = r4[15:0];
            else nrow = 16'd1;
        end else nrow = r2[15:0];
    end

    assign out_if.valid = r_out_valid;
    assign out_if.payload = r_out;
    assign o_item_take = take;

    always_comb begin
        take = 1'b0;
        stack_we = 1'b0;
        stack_waddr = AW'(r_sp);
        stack_wdata = suffix_rd;
        dict_we = 1'b0;
        if (r_state == S_IDLE && i_item_valid && !r_out_valid && !i_cfg_we) begin
            take = 1'b1;
            if (i_item.command == CMD_TICK && !r_fin && r_emitted < r_limit
                && r_sp == '0 && {2'b0, r_bits} >= {4'b0, r_csize}
                && {1'b0, code_now} >= clear_code + 13'd2
                && {1'b0, code_now} >= r_free) begin
                stack_we = 1'b1;
                stack_wdata = r_first;
            end
        end
        if (r_state == S_WALK && !link_in && r_sp < CW'(TABLE_ENTRIES)) begin
            stack_we = 1'b1;
            stack_wdata = r_cur[7:0];
            dict_we = !r_prev_clr && r_free < CW'(TABLE_ENTRIES);
        end
        if (r_state == S_READ && r_sp < CW'(TABLE_ENTRIES)) stack_we = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_size <= 4'd8;
            r_width <= 16'd1;
            r_height <= 16'd1;
            r_pitch <= 18'd1;
            r_interlaced <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CODE_SIZE: r_init_size <= i_cfg_data[3:0];
                REG_WIDTH: r_width <= i_cfg_data[15:0];
                REG_HEIGHT: r_height <= i_cfg_data[15:0];
                REG_PITCH: r_pitch <= i_cfg_data;
                REG_INTERLACED: r_interlaced <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= 32'(r_width * r_height);
        if (!i_rst_n || (i_cfg_we && i_cfg_idx <= REG_INTERLACED)) begin
            r_state <= S_IDLE;
            r_sp <= '0;
            r_acc <= '0;
            r_bits <= '0;
            r_csize <= (i_rst_n ? (eff_of(i_cfg_idx, i_cfg_data)) : 4'd8) + 4'd1;
            r_free <= CW'((13'd1 << (i_rst_n ? eff_of(i_cfg_idx, i_cfg_data) : 4'd8))
                          + 13'd2);
            r_prev <= '0;
            r_prev_clr <= 1'b0;
            r_first <= '0;
            r_row <= '0;
            r_col <= '0;
            r_emitted <= '0;
            r_fin <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (i_item.command == CMD_BYTE) begin
                            r_out_valid <= 1'b1;
                            if (r_bits > 6'd24) r_out <= status_only(ST_REFUSED);
                            else begin
                                r_acc <= r_acc | ({24'd0, i_item.data_byte} << r_bits);
                                r_bits <= r_bits + 6'd8;
                                r_out <= status_only(ST_NONE);
                            end
                        end else if (r_fin || r_emitted >= r_limit) begin
                            r_fin <= 1'b1;
                            r_sp <= '0;
                            r_out_valid <= 1'b1;
                            r_out <= status_only(ST_DONE);
                        end else if (r_sp != '0) begin
                            r_state <= S_POP;
                        end else if (r_bits < {2'b0, r_csize}) begin
                            r_out_valid <= 1'b1;
                            r_out <= status_only(ST_NEED_DATA);
                        end else begin
                            r_acc <= r_acc >> r_csize;
                            r_bits <= r_bits - {2'b0, r_csize};
                            r_code <= code_now;
                            if ({1'b0, code_now} == clear_code + 13'd1) begin
                                r_fin <= 1'b1;
                                r_out_valid <= 1'b1;
                                r_out <= status_only(ST_DONE);
                            end else if ({1'b0, code_now} == clear_code) begin
                                r_csize <= eff + 4'd1;
                                r_free <= CW'(clear_code + 13'd2);
                                r_prev <= code_now;
                                r_prev_clr <= 1'b1;
                                r_out_valid <= 1'b1;
                                r_out <= status_only(ST_NONE);
                            end else begin
                                if ({1'b0, code_now} < r_free) r_cur <= code_now;
                                else begin
                                    r_cur <= r_prev;
                                    r_sp <= CW'(1);
                                end
                                r_state <= S_WALK;
                            end
                        end
                    end
                end
                S_WALK: begin
                    if (r_sp >= CW'(TABLE_ENTRIES)) begin
                        r_sp <= '0;
                        r_fin <= 1'b1;
                        r_out <= status_only(ST_DONE);
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (link_in) begin
                        r_state <= S_READ;
                    end else begin
                        r_sp <= r_sp + CW'(1);
                        if (dict_we) begin
                            r_free <= r_free + CW'(1);
                            if ((r_free + CW'(1)) >= (CW'(1) << r_csize)
                                && r_csize < 4'(MAX_CODE_BITS))
                                r_csize <= r_csize + 4'd1;
                        end
                        r_first <= r_cur[7:0];
                        r_prev <= r_code;
                        r_prev_clr <= 1'b0;
                        r_state <= S_POP;
                    end
                end
                S_READ: begin
                    // Suffix and prefix of r_cur are now on the RAM outputs.
                    if (r_sp >= CW'(TABLE_ENTRIES)) begin
                        r_state <= S_WALK;
                    end else begin
                        r_sp <= r_sp + CW'(1);
                        r_cur <= prefix_rd;
                        r_state <= S_WALK;
                    end
                end
                S_POP: begin
                    r_sp <= r_sp - CW'(1);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_out.pixel_index <= stack_rd;
                    if (r_col >= r_width) begin
                        r_row <= nrow;
                        r_col <= '0;
                    end
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_addr <= 32'(r_row * r_pitch);
                    r_state <= S_ADDR;
                end
                default: begin
                    r_out <= {ST_PIXEL, r_out.pixel_index, r_row, r_col,
                              r_addr + {16'd0, r_col}};
                    r_out_valid <= 1'b1;
                    r_col <= r_col + 16'd1;
                    r_emitted <= r_emitted + 32'd1;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/gif_lzw_decoder_top.sv
// ------------------------------------------------------------------------
// GIF LZW decoder top level
// Decodes one GIF LZW image from de-blocked bytes into pixel items.
// ------------------------------------------------------------------------
// An item accepted into the front queue is taken by the back end once it is
// idle with no result waiting. A byte item is answered straight from the idle
// state into the output register, and so are a clear code, an end code and a
// tick that finds too few bits. A tick that pops a stacked pixel passes the
// pop, emit, row and address states; a tick that unpacks a code first walks
// the dictionary, with a read state for each link, set by the registered read
// of the prefix and suffix memories. Result items stay in an output register
// while the front queue keeps accepting items until it holds two.
`default_nettype none
module gif_lzw_decoder_top #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gld_stream_if.sink                         in_if,
    gld_stream_if.source                       out_if
);
    import gld_pkg::*;
    t_in_item item;
    logic     item_valid, item_take, flush;

    assign flush = i_cfg_we && (i_cfg_idx <= REG_INTERLACED);

    gld_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_flush(flush), .in_if(in_if),
        .o_item(item), .o_item_valid(item_valid), .i_item_take(item_take));

    gld_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_item(item), .i_item_valid(item_valid),
        .o_item_take(item_take), .out_if(out_if));
endmodule
`default_nettype wire

>>> rtl/core/gld_checker.sv
// ------------------------------------------------------------------------
// GIF LZW decoder checker
// Port-level properties of the decoder, bound to the top level.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module gld_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  out_status,
    input wire logic [7:0]  out_index,
    input wire logic [31:0] out_address
);
    import gld_pkg::*;
    `ASSERT_IMPL(a_status_range, i_clk, i_rst_n, out_valid, out_status <= ST_REFUSED, "bad status")
    `ASSERT_IMPL(a_zero_fields, i_clk, i_rst_n, out_valid && out_status != ST_PIXEL, out_index == 8'd0 && out_address == 32'd0, "nonzero fields")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "output dropped")
endmodule

bind gif_lzw_decoder_top gld_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_status(out_if.payload.status), .out_index(out_if.payload.pixel_index),
    .out_address(out_if.payload.pixel_address));
`default_nettype wire

>>> sim/tb_gif_lzw_decoder_top.sv
// ------------------------------------------------------------------------
// GIF LZW decoder testbench
// Drives LZW code streams (legal ones with random content, plus directed
// odd cases), byte refusals and stray ticks into the decoder. Each result item
// is checked against a predictor of the decoder that runs in the scoreboard class.
// ------------------------------------------------------------------------
`default_nettype none
module tb_gif_lzw_decoder_top;
    import gld_pkg::*;

    localparam int DICT_SIZE = 4096;
    localparam int MAX_BITS = 12;
    localparam int CYCLE_LIMIT = 2000000;

    class lzw_scoreboard;
        logic [11:0] prefix_mem [DICT_SIZE];
        logic [7:0]  suffix_mem [DICT_SIZE];
        logic [7:0]  char_stack [DICT_SIZE];
        int unsigned code_size_reg, width_reg, height_reg, pitch_reg, interlace_reg;
        int unsigned stack_depth, acc, bits_held, code_size, free_entry;
        int unsigned prev_code, prev_clear, prev_first, row, col, emitted;
        bit          finished;
        t_out_item   pending_results[$];
        int unsigned mismatches, checked;

        function new();
            code_size_reg = 8;
            width_reg = 1;
            height_reg = 1;
            pitch_reg = 1;
            interlace_reg = 0;
            mismatches = 0;
            checked = 0;
            restart();
        endfunction

        function int unsigned root_size();
            int unsigned s;
            s = code_size_reg & 15;
            if (s < 2) s = 2;
            if (s > 8) s = 8;
            return s;
        endfunction

        function void restart();
            stack_depth = 0;
            acc = 0;
            bits_held = 0;
            code_size = root_size() + 1;
            free_entry = (1 << root_size()) + 2;
            prev_code = 0;
            prev_clear = 0;
            prev_first = 0;
            row = 0;
            col = 0;
            emitted = 0;
            finished = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, int unsigned val);
            case (idx)
                REG_CODE_SIZE:  code_size_reg = val & 32'hF;
                REG_WIDTH:      width_reg = val & 32'hFFFF;
                REG_HEIGHT:     height_reg = val & 32'hFFFF;
                REG_PITCH:      pitch_reg = val & 32'h3FFFF;
                REG_INTERLACED: interlace_reg = val & 1;
                default: return;
            endcase
            restart();
        endfunction

        function int unsigned advance_row(int unsigned r);
            if (interlace_reg == 0) return r + 1;
            // Pass order is rows 0 mod 8, then 4 mod 8, then 2 mod 4, then odd rows.
            if ((r & 7) == 0) begin
                r += 8;
                if (r >= height_reg) begin
                    r = 4;
                    if (r >= height_reg) begin
                        r = 2;
                        if (r >= height_reg) r = 1;
                    end
                end
            end else if ((r & 3) == 0) begin
                r += 8;
                if (r >= height_reg) begin
                    r = 2;
                    if (r >= height_reg) r = 1;
                end
            end else if ((r & 1) == 0) begin
                r += 4;
                if (r >= height_reg) r = 1;
            end else begin
                r += 2;
            end
            return r;
        endfunction

        function bit push_char(int unsigned c);
            if (stack_depth >= DICT_SIZE) return 0;
            char_stack[stack_depth] = c[7:0];
            stack_depth++;
            return 1;
        endfunction

        function bit unpack_string(int unsigned code);
            int unsigned first_free, link;
            first_free = (1 << root_size()) + 2;
            if (code < free_entry) begin
                link = code;
            end else begin
                if (!push_char(prev_first)) return 0;
                link = prev_code;
            end
            while (link >= first_free && link < DICT_SIZE) begin
                if (!push_char(suffix_mem[link])) return 0;
                link = prefix_mem[link];
            end
            if (!push_char(link)) return 0;
            link &= 8'hFF;
            if (prev_clear == 0 && free_entry < DICT_SIZE) begin
                prefix_mem[free_entry] = prev_code[11:0];
                suffix_mem[free_entry] = link[7:0];
                free_entry++;
                if (free_entry >= (1 << code_size) && code_size < MAX_BITS) code_size++;
            end
            prev_first = link;
            prev_code = code;
            prev_clear = 0;
            return 1;
        endfunction

        function void queue_result(t_out_item r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void note_input(t_in_item it);
            t_out_item   r;
            int unsigned lim, code, s;
            r = '0;
            lim = width_reg * height_reg;
            if (it.command == CMD_BYTE) begin
                if (bits_held > 24) begin
                    r.status = ST_REFUSED;
                end else begin
                    acc |= 32'(it.data_byte) << bits_held;
                    bits_held += 8;
                    r.status = ST_NONE;
                end
                queue_result(r);
                return;
            end
            if (finished || emitted >= lim) begin
                finished = 1;
                stack_depth = 0;
                r.status = ST_DONE;
                queue_result(r);
                return;
            end
            if (stack_depth == 0) begin
                if (bits_held < code_size) begin
                    r.status = ST_NEED_DATA;
                    queue_result(r);
                    return;
                end
                code = acc & ((1 << code_size) - 1);
                acc >>= code_size;
                bits_held -= code_size;
                s = root_size();
                if (code == (1 << s) + 1) begin
                    finished = 1;
                    r.status = ST_DONE;
                    queue_result(r);
                    return;
                end
                if (code == (1 << s)) begin
                    code_size = s + 1;
                    free_entry = (1 << s) + 2;
                    prev_code = code;
                    prev_clear = 1;
                    r.status = ST_NONE;
                    queue_result(r);
                    return;
                end
                if (!unpack_string(code)) begin
                    stack_depth = 0;
                    finished = 1;
                    r.status = ST_DONE;
                    queue_result(r);
                    return;
                end
            end
            stack_depth--;
            if (col >= width_reg) begin
                row = advance_row(row) & 32'hFFFF;
                col = 0;
            end
            r.status = ST_PIXEL;
            r.pixel_index = char_stack[stack_depth % DICT_SIZE];
            r.pixel_row = row[15:0];
            r.pixel_column = col[15:0];
            r.pixel_address = row * pitch_reg + col;
            col = (col + 1) & 32'hFFFF;
            emitted++;
            queue_result(r);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report($sformatf("result item with nothing expected: %p", got));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.pixel_index !== want.pixel_index)
                report($sformatf("pixel_index %0d, expected %0d",
                    got.pixel_index, want.pixel_index));
            if (got.pixel_row !== want.pixel_row)
                report($sformatf("pixel_row %0d, expected %0d", got.pixel_row, want.pixel_row));
            if (got.pixel_column !== want.pixel_column)
                report($sformatf("pixel_column %0d, expected %0d",
                    got.pixel_column, want.pixel_column));
            if (got.pixel_address !== want.pixel_address)
                report($sformatf("pixel_address %0h, expected %0h",
                    got.pixel_address, want.pixel_address));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gld_stream_if #(.T(t_in_item)) in_ch ();
    gld_stream_if #(.T(t_out_item)) out_ch ();

    gif_lzw_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_if      (in_ch),
        .out_if     (out_ch)
    );

    lzw_scoreboard sb = new();
    bit          gaps_on = 1;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned frames_run = 0;

    // Encoder-side view of the dictionary, used to keep code streams legal.
    int unsigned enc_root, enc_free, enc_size, enc_clear;
    bit          enc_bits[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= gaps_on ? ($urandom_range(99) >= 16) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
    end

    task automatic send_item(input logic cmd, input logic [7:0] data);
        t_in_item it;
        it.command = cmd;
        it.data_byte = data;
        while (gaps_on && $urandom_range(99) < 16) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (sb.pending_results.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.configure(idx, val);
    endtask

    task automatic set_frame(input int unsigned cs, input int unsigned w, input int unsigned h,
                             input int unsigned pitch, input int unsigned il);
        int unsigned s;
        go_idle();
        write_reg(REG_CODE_SIZE, cs);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_PITCH, pitch);
        write_reg(REG_INTERLACED, il);
        i_cfg_we <= 1'b0;
        s = cs & 15;
        if (s < 2) s = 2;
        if (s > 8) s = 8;
        enc_root = s;
        enc_size = s + 1;
        enc_free = (1 << s) + 2;
        enc_clear = 0;
        enc_bits.delete();
        frames_run++;
    endtask

    task automatic add_code(input int unsigned code);
        for (int i = 0; i < enc_size; i++) enc_bits = {enc_bits, code[i]};
        if (code == (1 << enc_root)) begin
            enc_size = enc_root + 1;
            enc_free = (1 << enc_root) + 2;
            enc_clear = 1;
        end else if (code != (1 << enc_root) + 1) begin
            if (!enc_clear && enc_free < DICT_SIZE) begin
                enc_free++;
                if (enc_free >= (1 << enc_size) && enc_size < MAX_BITS) enc_size++;
            end
            enc_clear = 0;
        end
    endtask

    // Only codes the decoder already knows, or the one it is about to add,
    // so no chain ever reaches a dictionary entry that was never filled.
    function automatic int unsigned pick_code(input bit literal_heavy);
        int unsigned lit_top, first_free, roll;
        lit_top = (1 << enc_root) - 1;
        first_free = (1 << enc_root) + 2;
        roll = $urandom_range(99);
        if (enc_clear) return $urandom_range(lit_top);
        if (literal_heavy) begin
            if (roll < 97) return $urandom_range(lit_top);
            return enc_free;
        end
        if (roll < 4) return 1 << enc_root;
        if (roll < 45 || enc_free <= first_free) return $urandom_range(lit_top);
        if (roll < 88) return $urandom_range(first_free, enc_free - 1);
        return enc_free;
    endfunction

    task automatic play_stream(input int unsigned tail_ticks);
        logic [7:0] bytes[$];
        logic [7:0] b;
        int unsigned guard;
        add_code((1 << enc_root) + 1);
        while (enc_bits.size() > 0) begin
            b = '0;
            for (int i = 0; i < 8; i++) if (enc_bits.size() > 0) b[i] = enc_bits.pop_front();
            bytes = {bytes, b};
        end
        guard = 0;
        while (tail_ticks > 0 && guard < 400000) begin
            guard++;
            if (sb.finished) begin
                // Bytes still go in after the frame ends and fill the buffer.
                if (bytes.size() > 6) bytes.delete();
                if (bytes.size() > 0 && $urandom_range(1)) begin
                    send_item(CMD_BYTE, bytes.pop_front());
                end else begin
                    send_item(CMD_TICK, 8'($urandom));
                    tail_ticks--;
                end
            end else if (bytes.size() > 0 &&
                         $urandom_range(99) < (sb.bits_held > 24 ? 4 : 55)) begin
                if (sb.bits_held > 24) send_item(CMD_BYTE, bytes[0]);
                else send_item(CMD_BYTE, bytes.pop_front());
            end else begin
                send_item(CMD_TICK, 8'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned n, cs, w, h, pitch;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_CODE_SIZE;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Clear, then an unknown code right after it, then end of image.
        set_frame(2, 3, 2, 262143, 0);
        add_code(4);
        add_code(6);
        play_stream(2);
        // Code size below range, and a pixel limit reached before the last codes.
        set_frame(1, 2, 2, 1, 1);
        add_code(1);
        add_code(6);
        add_code(3);
        add_code(7);
        add_code(8);
        play_stream(2);
        // Empty frames and the widest settings.
        set_frame(15, 0, 5, 7, 0);
        play_stream(1);
        set_frame(0, 65535, 0, 0, 1);
        play_stream(1);
        set_frame(8, 65535, 65535, 262143, 0);
        add_code(255);
        add_code(0);
        add_code(258);
        play_stream(2);

        while (items_sent < 1200) begin
            gaps_on = !(frames_run >= 12 && frames_run < 20);
            cs = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2, 8);
            w = ($urandom_range(19) == 0) ? 65535 : $urandom_range(1, 12);
            h = (w == 65535) ? 1 : $urandom_range(1, 12);
            case ($urandom_range(3))
                0: pitch = 262143;
                1: pitch = $urandom_range(1, 16);
                default: pitch = $urandom_range(262143);
            endcase
            set_frame(cs, w, h, pitch, $urandom_range(1));
            if ($urandom_range(1)) add_code(1 << enc_root);
            n = $urandom_range(3, 40);
            for (int i = 0; i < n; i++) add_code(pick_code(0));
            play_stream($urandom_range(1, 3));
        end

        // One long frame whose dictionary grows the code size well past its start.
        gaps_on = 1;
        set_frame(2, 65535, 1, 3, 0);
        for (int i = 0; i < 300; i++) add_code(pick_code(1));
        play_stream(2);

        in_ch.valid <= 1'b0;
        fork
            wait (sb.pending_results.size() == 0);
            wait (cycle_count > CYCLE_LIMIT);
        join_any
        repeat (50) @(posedge i_clk);
        $display("Ran %0d frames with %0d input items and %0d checked results.",
            frames_run, items_sent, sb.checked);
        $display("Frames covered clamped code sizes, interlace, refusals and code size growth.");
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results never arrived",
                sb.mismatches, sb.pending_results.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
